// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define HRGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define HRGB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/hrgb_pkg.sv
// types, register indexes and helpers for the half rgba to rgb8 converter
package hrgb_pkg;

  localparam int unsigned HalfW  = 16;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned DepthW = 4;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned SigW   = 11;
  localparam int unsigned ProdW  = SigW + ChanW;
  localparam int unsigned ShiftW = 5;

  typedef enum logic [IdxW-1:0] {
    REG_BIT_DEPTH        = 8'd0,
    REG_BACKGROUND_RED   = 8'd1,
    REG_BACKGROUND_GREEN = 8'd2,
    REG_BACKGROUND_BLUE  = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } adv_t;

  function automatic logic [ChanW-1:0] full_scale(input logic [DepthW-1:0] depth);
    logic [ChanW-1:0] full;
    unique case (depth)
      4'd0, 4'd1: full = 8'd1;
      4'd2:       full = 8'd3;
      4'd3:       full = 8'd7;
      4'd4:       full = 8'd15;
      4'd5:       full = 8'd31;
      4'd6:       full = 8'd63;
      4'd7:       full = 8'd127;
      default:    full = 8'd255;
    endcase
    return full;
  endfunction

  // floor(x / 255) for x below 65280
  function automatic logic [ChanW-1:0] div255(input logic [2*ChanW-1:0] x);
    logic [2*ChanW:0] sum;
    sum = {1'b0, x} + {{(2*ChanW){1'b0}}, 1'b1}
        + {{(ChanW+1){1'b0}}, x[2*ChanW-1:ChanW]};
    return sum[2*ChanW-1:ChanW];
  endfunction

endpackage

// File: rtl/hrgb_quant.sv
// two-stage quantizer of one binary16 channel to [0, full]
module hrgb_quant (
  input  logic                         clk,
  input  hrgb_pkg::adv_t               adv,
  input  logic [hrgb_pkg::HalfW-1:0]   half,
  input  logic [hrgb_pkg::ChanW-1:0]   full,
  output logic [hrgb_pkg::ChanW-1:0]   q
);

  logic                          neg;
  logic [4:0]                    ex;
  logic [9:0]                    man;
  logic [hrgb_pkg::SigW-1:0]     sig;

  logic                          force_zero;
  logic                          force_full;
  logic [hrgb_pkg::ProdW-1:0]    prod;
  logic [hrgb_pkg::ShiftW-1:0]   shift;

  logic [hrgb_pkg::ProdW-1:0]    half_shift;
  logic [hrgb_pkg::ProdW-1:0]    rounded;
  logic [hrgb_pkg::ChanW-1:0]    q_next;

  assign neg = half[15];
  assign ex  = half[14:10];
  assign man = half[9:0];
  assign sig = (ex == 5'd0) ? {1'b0, man} : {1'b1, man};

  // stage 1: classify and form the exact product
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      force_zero <= neg || ((ex == 5'd31) && (man != 10'd0));
      force_full <= !neg && ((ex == 5'd31) ? (man == 10'd0) : (ex >= 5'd25));
      prod       <= {{(hrgb_pkg::ProdW-hrgb_pkg::SigW){1'b0}}, sig}
                  * {{(hrgb_pkg::ProdW-hrgb_pkg::ChanW){1'b0}}, full};
      shift      <= (ex == 5'd0) ? 5'd24 : (5'd25 - ex);
    end
  end

  // stage 2: shift right, round half away from zero, clamp
  always_comb begin
    half_shift = prod >> (shift - 5'd1);
    rounded    = (half_shift >> 1) + {{(hrgb_pkg::ProdW-1){1'b0}}, half_shift[0]};
    priority if (force_zero) begin
      q_next = '0;
    end else if (force_full) begin
      q_next = full;
    end else if (rounded > {{(hrgb_pkg::ProdW-hrgb_pkg::ChanW){1'b0}}, full}) begin
      q_next = full;
    end else begin
      q_next = rounded[hrgb_pkg::ChanW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      q <= q_next;
    end
  end

endmodule

// File: rtl/half_rgba_to_rgb8_premultiply.sv
// top level: binary16 rgba pixel to premultiplied 8-bit rgb pixel
//
// Input channel: in_valid / in_stall with red_half, green_half, blue_half and
// alpha_half as binary16 bit patterns; a transfer takes place at a rising edge
// with in_valid high and in_stall low. Output channel: out_valid / out_stall
// with red_out, green_out and blue_out, same transfer rule.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Index 0 bit_depth, 1..3 background red, green, blue; other
// indexes are ignored. Write only while no pixel is in flight.
// Four register stages: quantizer product, round and clamp, alpha multiply,
// divide by 255 with background select; valid passes v1, v2, v3, out_valid.
// Throughput is one pixel per cycle unless stalled; each stage register holds
// a valid bit and loads whenever it is empty or the stage after it moves.
// When the receiver stalls the pipeline fills up, and in_stall rises once all
// four stages hold pixels; nothing is dropped or repeated.
// Synchronous reset empties the pipeline, sets bit_depth to 8 and the
// background colour to black.
`include "assert_macros.svh"

module half_rgba_to_rgb8_premultiply (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hrgb_pkg::HalfW-1:0]    red_half,
  input  logic [hrgb_pkg::HalfW-1:0]    green_half,
  input  logic [hrgb_pkg::HalfW-1:0]    blue_half,
  input  logic [hrgb_pkg::HalfW-1:0]    alpha_half,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hrgb_pkg::ChanW-1:0]    red_out,
  output logic [hrgb_pkg::ChanW-1:0]    green_out,
  output logic [hrgb_pkg::ChanW-1:0]    blue_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hrgb_pkg::IdxW-1:0]     cfg_index,
  input  logic [hrgb_pkg::ChanW-1:0]    cfg_data
);

  logic [hrgb_pkg::ChanW-1:0]   full;
  logic [hrgb_pkg::ChanW-1:0]   background_red;
  logic [hrgb_pkg::ChanW-1:0]   background_green;
  logic [hrgb_pkg::ChanW-1:0]   background_blue;

  logic                         v1, v2, v3;
  logic                         ld1, ld2, ld3, ld4;
  hrgb_pkg::adv_t               adv;

  logic [hrgb_pkg::ChanW-1:0]   r_q, g_q, b_q, a_q;
  logic [2*hrgb_pkg::ChanW-1:0] r_prod, g_prod, b_prod;
  logic                         alpha_zero;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      full             <= hrgb_pkg::full_scale(4'd8);
      background_red   <= '0;
      background_green <= '0;
      background_blue  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hrgb_pkg::REG_BIT_DEPTH:
          full <= hrgb_pkg::full_scale(cfg_data[hrgb_pkg::DepthW-1:0]);
        hrgb_pkg::REG_BACKGROUND_RED:   background_red   <= cfg_data;
        hrgb_pkg::REG_BACKGROUND_GREEN: background_green <= cfg_data;
        hrgb_pkg::REG_BACKGROUND_BLUE:  background_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage load enables, back to front
  assign ld4      = !out_valid || !out_stall;
  assign ld3      = !v3 || ld4;
  assign ld2      = !v2 || ld3;
  assign ld1      = !v1 || ld2;
  assign in_stall = !ld1;
  assign adv.s1   = ld1;
  assign adv.s2   = ld2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= in_valid;
      end
      if (ld2) begin
        v2 <= v1;
      end
      if (ld3) begin
        v3 <= v2;
      end
      if (ld4) begin
        out_valid <= v3;
      end
    end
  end

  hrgb_quant u_quant_red (
    .clk  (clk),
    .adv  (adv),
    .half (red_half),
    .full (full),
    .q    (r_q)
  );

  hrgb_quant u_quant_green (
    .clk  (clk),
    .adv  (adv),
    .half (green_half),
    .full (full),
    .q    (g_q)
  );

  hrgb_quant u_quant_blue (
    .clk  (clk),
    .adv  (adv),
    .half (blue_half),
    .full (full),
    .q    (b_q)
  );

  hrgb_quant u_quant_alpha (
    .clk  (clk),
    .adv  (adv),
    .half (alpha_half),
    .full (full),
    .q    (a_q)
  );

  // stage 3: multiply by quantized alpha
  always_ff @(posedge clk) begin
    if (ld3) begin
      r_prod     <= {{hrgb_pkg::ChanW{1'b0}}, r_q} * {{hrgb_pkg::ChanW{1'b0}}, a_q};
      g_prod     <= {{hrgb_pkg::ChanW{1'b0}}, g_q} * {{hrgb_pkg::ChanW{1'b0}}, a_q};
      b_prod     <= {{hrgb_pkg::ChanW{1'b0}}, b_q} * {{hrgb_pkg::ChanW{1'b0}}, a_q};
      alpha_zero <= (a_q == '0);
    end
  end

  // stage 4: divide by 255 or take the background colour
  always_ff @(posedge clk) begin
    if (ld4) begin
      if (alpha_zero) begin
        red_out   <= background_red;
        green_out <= background_green;
        blue_out  <= background_blue;
      end else begin
        red_out   <= hrgb_pkg::div255(r_prod);
        green_out <= hrgb_pkg::div255(g_prod);
        blue_out  <= hrgb_pkg::div255(b_prod);
      end
    end
  end

  `HRGB_ASSERT(a_quant_in_range, v2 |-> ((r_q <= full) && (a_q <= full)), "quantized value above full scale")
  `HRGB_ASSERT(a_background, (v3 && ld4 && alpha_zero) |=> (red_out == $past(background_red)), "background not selected for zero alpha")
  `HRGB_ASSERT(a_premul_range, (v3 && ld4 && !alpha_zero) |=> ((red_out <= $past(full)) && (blue_out <= $past(full))), "premultiplied value above full scale")
  `HRGB_ASSERT_ALWAYS(a_stall_only_full, in_stall |-> (v1 && v2 && v3 && out_valid), "input stalled with an empty stage")

endmodule

// File: tb/sv/tb.sv
// testbench for the binary16 rgba to premultiplied 8-bit rgb converter
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hrgb_pkg::*;

  localparam int unsigned ALPHA_ONE       = 255;
  localparam int unsigned NUM_PHASES      = 12;
  localparam int unsigned PIXELS_PER_PHASE = 128;
  localparam int unsigned PRESSURE_PHASE  = 3;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam logic [4:0]  EXP_ALL_ONES    = 5'h1f;
  localparam logic [IdxW-1:0] FIRST_UNUSED_INDEX = REG_BACKGROUND_BLUE + 1;

  typedef struct packed {
    logic [HalfW-1:0] red;
    logic [HalfW-1:0] green;
    logic [HalfW-1:0] blue;
    logic [HalfW-1:0] alpha;
  } half_pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb8_t;

  typedef struct packed {
    logic [IdxW-1:0]  index;
    logic [ChanW-1:0] data;
  } reg_write_t;

  localparam logic [63:0] DIRECTED_PX [16] = '{
    64'h0000_0000_0000_0000,
    64'h3C00_3C00_3C00_3C00,
    64'h7C00_7C00_7C00_7C00,
    64'hFC00_7E00_FE00_3C00,
    64'h8000_BC00_7C01_3C00,
    64'h3800_3800_3800_3800,
    64'h0001_03FF_0400_3C00,
    64'h7BFF_FBFF_FFFF_3C00,
    64'h3C00_3C00_3C00_7E00,
    64'h3C00_3C00_3C00_FC00,
    64'h3800_3400_3000_7C00,
    64'h3C00_3C00_3C00_0001,
    64'h3C00_3C00_3C00_8000,
    64'h1C04_1BFF_1C00_3C00,
    64'h3C00_3800_0000_1C04,
    64'h5BFF_7FFF_0000_3BFF
  };

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             in_valid   = 1'b0;
  logic             in_stall;
  logic [HalfW-1:0] red_half   = '0;
  logic [HalfW-1:0] green_half = '0;
  logic [HalfW-1:0] blue_half  = '0;
  logic [HalfW-1:0] alpha_half = '0;
  logic             out_valid;
  logic             out_stall  = 1'b0;
  logic [ChanW-1:0] red_out;
  logic [ChanW-1:0] green_out;
  logic [ChanW-1:0] blue_out;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [IdxW-1:0]  cfg_index  = '0;
  logic [ChanW-1:0] cfg_data   = '0;

  logic idle_on  = 1'b1;
  logic hold_off = 1'b0;

  logic [DepthW-1:0] depth_setting = 4'd8;
  logic [ChanW-1:0]  bg_red        = '0;
  logic [ChanW-1:0]  bg_green      = '0;
  logic [ChanW-1:0]  bg_blue       = '0;

  half_pixel_t pending_pixels[$];
  rgb8_t       premult_expected[$];
  reg_write_t  reg_writes[$];
  half_pixel_t offered;
  int          send_gap    = 0;
  int          stall_left  = 0;
  int          error_count = 0;
  int unsigned cycle_count = 0;

  half_rgba_to_rgb8_premultiply dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red_half   (red_half),
    .green_half (green_half),
    .blue_half  (blue_half),
    .alpha_half (alpha_half),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // scale by full, round half away from zero, clamp
  function automatic logic [ChanW-1:0] quantize_channel(logic [HalfW-1:0] h,
                                                        logic [ChanW-1:0] full);
    logic [4:0]       ex;
    logic [9:0]       man;
    logic [SigW-1:0]  sig;
    logic [ProdW-1:0] prod;
    logic [31:0]      q;
    int               e2;
    int               k;
    ex  = h[14:10];
    man = h[9:0];
    if (ex == EXP_ALL_ONES)
      return (man == '0 && !h[15]) ? full : '0;
    if (h[15])
      return '0;
    if (ex == '0) begin
      sig = {1'b0, man};
      e2  = -24;
    end else begin
      sig = {1'b1, man};
      e2  = int'(ex) - 25;
    end
    prod = sig * full;
    if (e2 >= 0) begin
      q = 32'(prod) << e2;
    end else begin
      k = -e2;
      q = (32'(prod) >> k) + ((32'(prod) >> (k - 1)) & 32'd1);
    end
    return (q > 32'(full)) ? full : q[ChanW-1:0];
  endfunction

  function automatic rgb8_t premultiply_pixel(half_pixel_t px);
    logic [DepthW-1:0] d;
    logic [ChanW-1:0]  full;
    logic [ChanW-1:0]  r, g, b, a;
    rgb8_t             res;
    d = depth_setting;
    if (d < 4'd1)
      d = 4'd1;
    else if (d > 4'd8)
      d = 4'd8;
    full = 8'((9'd1 << d) - 9'd1);
    r = quantize_channel(px.red, full);
    g = quantize_channel(px.green, full);
    b = quantize_channel(px.blue, full);
    a = quantize_channel(px.alpha, full);
    if (a == '0) begin
      res.red   = bg_red;
      res.green = bg_green;
      res.blue  = bg_blue;
    end else begin
      res.red   = 8'((32'(r) * 32'(a)) / ALPHA_ONE);
      res.green = 8'((32'(g) * 32'(a)) / ALPHA_ONE);
      res.blue  = 8'((32'(b) * 32'(a)) / ALPHA_ONE);
    end
    return res;
  endfunction

  function automatic logic [HalfW-1:0] random_half();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55)
      return {1'b0, 5'($urandom_range(14)), 10'($urandom)};
    if (pick < 70)
      return 16'($urandom);
    if (pick < 80)
      return {1'b0, 5'($urandom_range(30, 15)), 10'($urandom)};
    if (pick < 88)
      return {1'b0, 5'($urandom_range(5)), 10'($urandom)};
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7C00;
      3: return 16'hFC00;
      4: return 16'h7E00;
      5: return 16'hFE00;
      6: return {6'b011111, 10'($urandom)};
      7: return 16'h3800;
      8: return 16'hBC00;
      default: return 16'h3C00;
    endcase
  endfunction

  // mostly visible alpha so the premultiply path sees real work
  function automatic logic [HalfW-1:0] random_alpha();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4)
      return {1'b0, 5'($urandom_range(14, 11)), 10'($urandom)};
    if (pick == 4)
      return 16'h3C00;
    return random_half();
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%s", msg);
  endfunction

  task automatic program_regs();
    reg_write_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.index;
      cfg_data  <= w.data;
      do @(posedge clk); while (!cfg_ready);
      case (w.index)
        REG_BIT_DEPTH:        depth_setting = w.data[DepthW-1:0];
        REG_BACKGROUND_RED:   bg_red        = w.data;
        REG_BACKGROUND_GREEN: bg_green      = w.data;
        REG_BACKGROUND_BLUE:  bg_blue       = w.data;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || premult_expected.size() != 0 || in_valid);
    @(posedge clk);
  endtask

  always @(posedge clk) begin : drive
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        premult_expected.push_back(premultiply_pixel(offered));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(7) == 0) begin
          send_gap = $urandom_range(14);
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          offered = pending_pixels.pop_front();
          in_valid   <= 1'b1;
          red_half   <= offered.red;
          green_half <= offered.green;
          blue_half  <= offered.blue;
          alpha_half <= offered.alpha;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : observe
    rgb8_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (premult_expected.size() == 0) begin
          note_error($sformatf("unexpected transfer: r=%0d g=%0d b=%0d",
                               red_out, green_out, blue_out));
        end else begin
          want = premult_expected.pop_front();
          if (want.red !== red_out || want.green !== green_out || want.blue !== blue_out)
            note_error($sformatf("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want.red, want.green, want.blue,
                                 red_out, green_out, blue_out));
        end
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[half_rgba_to_rgb8_premultiply] ERROR");
      $finish;
    end
  end

  initial begin
    logic [DepthW-1:0] depths [NUM_PHASES];
    half_pixel_t       px;
    logic [ChanW-1:0]  bg;
    depths = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd9, 4'd8};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings first
    for (int i = 0; i < 16; i++)
      pending_pixels.push_back(half_pixel_t'(DIRECTED_PX[i]));
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      reg_writes.push_back('{REG_BIT_DEPTH, {4'($urandom), depths[p]}});
      for (int c = 0; c < 3; c++) begin
        if (p == 0)
          bg = 8'hFF;
        else if (p == 1)
          bg = 8'h00;
        else
          bg = 8'($urandom);
        case (c)
          0: reg_writes.push_back('{REG_BACKGROUND_RED, bg});
          1: reg_writes.push_back('{REG_BACKGROUND_GREEN, bg});
          default: reg_writes.push_back('{REG_BACKGROUND_BLUE, bg});
        endcase
      end
      reg_writes.push_back('{8'($urandom_range(255, FIRST_UNUSED_INDEX)), 8'($urandom)});
      program_regs();

      idle_on <= (p == NUM_PHASES - 1) ? 1'b0 : ($urandom_range(3) != 0);
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        px.red   = random_half();
        px.green = random_half();
        px.blue  = random_half();
        px.alpha = random_alpha();
        pending_pixels.push_back(px);
      end
      if (p == PRESSURE_PHASE) begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && premult_expected.size() == 0)
      $display("[half_rgba_to_rgb8_premultiply] OK");
    else
      $display("[half_rgba_to_rgb8_premultiply] ERROR");
    $finish;
  end

endmodule
